// ===== rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// No dependencies; used by lr_line_engine and line_rasterizer_top.
package lr_pkg;

	// Command codes carried on the func field
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	localparam int unsigned COLOR_BITS = 24;

	// Control side of one engine result
	typedef struct packed {
		logic pix_valid;
		logic last;
	} pix_ctl_t;

endpackage

// ===== rtl/lr_line_engine.sv =====
// Line state and per-word Bresenham logic: load setup and one pixel step.
// Depends on lr_pkg.
module lr_line_engine #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic                             func,
	input  logic signed [COORD_BITS-1:0]     x_start,
	input  logic signed [COORD_BITS-1:0]     y_start,
	input  logic signed [COORD_BITS-1:0]     x_end,
	input  logic signed [COORD_BITS-1:0]     y_end,
	input  logic [lr_pkg::COLOR_BITS-1:0]    line_color,
	output lr_pkg::pix_ctl_t                 ctl,
	output logic signed [COORD_BITS-1:0]     pixel_x,
	output logic signed [COORD_BITS-1:0]     pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]    pixel_rgb
);

	localparam int unsigned DB = COORD_BITS + 1;
	localparam int unsigned EB = COORD_BITS + 4;

	logic                            active_q;
	logic                            x_is_major_q;
	logic                            minor_rises_q;
	logic signed [COORD_BITS-1:0]    major_pos_q;
	logic signed [COORD_BITS-1:0]    minor_pos_q;
	logic signed [COORD_BITS-1:0]    major_stop_q;
	logic [DB-1:0]                   major_delta_q;
	logic [DB-1:0]                   minor_delta_q;
	logic signed [EB-1:0]            error_term_q;
	logic [lr_pkg::COLOR_BITS-1:0]   held_color_q;

	logic is_load;
	logic is_step;
	assign is_load = (lr_pkg::func_t'(func) == lr_pkg::FUNC_LOAD);
	assign is_step = (lr_pkg::func_t'(func) == lr_pkg::FUNC_STEP);

	// Load setup: pick the major axis and order the endpoints
	logic signed [DB-1:0]         dx, dy, dmin_s;
	logic [DB-1:0]                adx, ady;
	logic                         ld_x_major;
	logic signed [COORD_BITS-1:0] a0, b0, a1, b1, ma0, mb0, ma1, mb1;
	logic                         swap;
	logic [DB-1:0]                ld_major_delta, ld_minor_delta;

	always_comb begin
		dx = $signed({x_end[COORD_BITS-1], x_end}) - $signed({x_start[COORD_BITS-1], x_start});
		dy = $signed({y_end[COORD_BITS-1], y_end}) - $signed({y_start[COORD_BITS-1], y_start});
		adx = dx[DB-1] ? DB'(-dx) : DB'(dx);
		ady = dy[DB-1] ? DB'(-dy) : DB'(dy);
		ld_x_major = adx > ady;
		if (ld_x_major) begin
			a0 = x_start; b0 = y_start; a1 = x_end; b1 = y_end;
		end else begin
			a0 = y_start; b0 = x_start; a1 = y_end; b1 = x_end;
		end
		swap = a0 > a1;
		ma0 = swap ? a1 : a0;
		mb0 = swap ? b1 : b0;
		ma1 = swap ? a0 : a1;
		mb1 = swap ? b0 : b1;
		ld_major_delta = DB'($signed({ma1[COORD_BITS-1], ma1}) - $signed({ma0[COORD_BITS-1], ma0}));
		dmin_s = $signed({mb1[COORD_BITS-1], mb1}) - $signed({mb0[COORD_BITS-1], mb0});
		ld_minor_delta = dmin_s[DB-1] ? DB'(-dmin_s) : DB'(dmin_s);
	end

	// Step: update the error term and the minor coordinate
	logic signed [EB-1:0]         two_min, two_maj, err_next;
	logic signed [COORD_BITS-1:0] minor_next;
	logic                         fin;

	always_comb begin
		two_min = $signed({2'b00, minor_delta_q, 1'b0});
		two_maj = $signed({2'b00, major_delta_q, 1'b0});
		if (error_term_q <= 0) begin
			minor_next = minor_pos_q;
			err_next = error_term_q + two_min;
		end else begin
			minor_next = minor_rises_q ? minor_pos_q + 1'b1 : minor_pos_q - 1'b1;
			err_next = error_term_q + two_min - two_maj;
		end
		fin = major_pos_q >= major_stop_q;
	end

	// Drive the pixel for the word being processed
	always_comb begin
		ctl.pix_valid = go && is_step && active_q;
		ctl.last = fin;
		pixel_x = x_is_major_q ? major_pos_q : minor_next;
		pixel_y = x_is_major_q ? minor_next : major_pos_q;
		pixel_rgb = held_color_q;
	end

	// Hold line state; load replaces it, step advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			x_is_major_q  <= 1'b0;
			minor_rises_q <= 1'b0;
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_stop_q  <= '0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			error_term_q  <= '0;
			held_color_q  <= '0;
		end else if (go && is_load) begin
			active_q      <= 1'b1;
			x_is_major_q  <= ld_x_major;
			minor_rises_q <= mb1 >= mb0;
			major_pos_q   <= ma0;
			minor_pos_q   <= mb0;
			major_stop_q  <= ma1;
			major_delta_q <= ld_major_delta;
			minor_delta_q <= ld_minor_delta;
			error_term_q  <= '0;
			held_color_q  <= line_color;
		end else if (go && is_step && active_q) begin
			minor_pos_q  <= minor_next;
			error_term_q <= err_next;
			if (fin) begin
				active_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + 1'b1;
			end
		end
	end

	// A load always arms the line
	a_load_arms: assert property (@(posedge clk) disable iff (!arst_n)
		go && is_load |=> active_q)
		else $error("line not active after load");

	// The final pixel disarms the line
	a_last_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pix_valid && fin |=> !active_q)
		else $error("line still active after final pixel");

	// An idle engine emits nothing
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !ctl.pix_valid)
		else $error("pixel emitted while idle");

endmodule

// ===== rtl/line_rasterizer_top.sv =====
// Top level of the line rasterizer: input register, line engine, result register.
// Depends on lr_pkg and lr_line_engine.
// A step word waits in the input register; its pixel is captured in the result register.
// Throughput: one word per cycle unless stalled, set by the single compare-and-add step.
// Load words produce no pixel; steps while no line is active produce nothing.
// Reset (arst_n low, asynchronous) empties both registers and leaves no line active.
module line_rasterizer_top #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic signed [COORD_BITS-1:0]     x_start,
	input  logic signed [COORD_BITS-1:0]     y_start,
	input  logic signed [COORD_BITS-1:0]     x_end,
	input  logic signed [COORD_BITS-1:0]     y_end,
	input  logic [lr_pkg::COLOR_BITS-1:0]    line_color,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [COORD_BITS-1:0]     pixel_x,
	output logic signed [COORD_BITS-1:0]     pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]    pixel_rgb,
	output logic                             last
);

	logic                          valid_s1;
	logic                          func_s1;
	logic signed [COORD_BITS-1:0]  x_start_s1, y_start_s1, x_end_s1, y_end_s1;
	logic [lr_pkg::COLOR_BITS-1:0] color_s1;

	logic                          out_valid_q;
	logic signed [COORD_BITS-1:0]  pixel_x_q, pixel_y_q;
	logic [lr_pkg::COLOR_BITS-1:0] pixel_rgb_q;
	logic                          last_q;

	logic                          advance;
	logic                          go;
	lr_pkg::pix_ctl_t              eng_ctl;
	logic signed [COORD_BITS-1:0]  eng_x, eng_y;
	logic [lr_pkg::COLOR_BITS-1:0] eng_color;

	// The result register frees up when empty or when its word is taken
	assign advance  = !out_valid_q || !out_stall;
	assign go       = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register: load a new word whenever the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			func_s1    <= func;
			x_start_s1 <= x_start;
			y_start_s1 <= y_start;
			x_end_s1   <= x_end;
			y_end_s1   <= y_end;
			color_s1   <= line_color;
		end
	end

	lr_line_engine #(
		.COORD_BITS (COORD_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.func        (func_s1),
		.x_start     (x_start_s1),
		.y_start     (y_start_s1),
		.x_end       (x_end_s1),
		.y_end       (y_end_s1),
		.line_color  (color_s1),
		.ctl         (eng_ctl),
		.pixel_x     (eng_x),
		.pixel_y     (eng_y),
		.pixel_rgb   (eng_color)
	);

	// Result register: capture a pixel, or drop the word once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= eng_ctl.pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_x_q   <= eng_x;
			pixel_y_q   <= eng_y;
			pixel_rgb_q <= eng_color;
			last_q      <= eng_ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign pixel_rgb = pixel_rgb_q;
	assign last      = last_q;

	// Stall only ever comes from a held word
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked word");

	// A blocked result keeps the input word in place
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(func_s1) && $stable(x_start_s1))
		else $error("input word moved while stalled");

	// A pixel is produced only when the engine processes a word
	a_pix_from_go: assert property (@(posedge clk) disable iff (!arst_n)
		eng_ctl.pix_valid |-> go)
		else $error("engine pixel without processed word");

endmodule
